### rtl/core/lcbs_pkg.sv
`timescale 1ns / 1ps

package lcbs_pkg;

    // field widths
    localparam int DUTY_W = 8;
    localparam int KEY_W = 2;
    localparam int MENU_W = 2;
    localparam int MODE_W = 2;
    localparam int TICK_W = DUTY_W + 1;
    localparam int CFG_IDX_W = 1;

    // channels that have a duty field on the result word
    localparam int FIELD_CHANNELS = 4;
    localparam int CHANNELS_DEF = 4;

    // register reset values
    localparam logic [DUTY_W-1:0] HALF_RESET = DUTY_W'(10);
    localparam logic [DUTY_W-1:0] FULL_RESET = DUTY_W'(100);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_HALF = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_FULL = 1'b1;

    // key codes
    localparam logic [KEY_W-1:0] KEY_NEXT = 2'd1;
    localparam logic [KEY_W-1:0] KEY_SELECT = 2'd2;

    // menu entries
    localparam logic [MENU_W-1:0] MENU_CHASE = 2'd0;
    localparam logic [MENU_W-1:0] MENU_BREATH = 2'd1;
    localparam logic [MENU_W-1:0] MENU_EXIT = 2'd2;

    typedef enum logic [MODE_W-1:0] {
        MODE_MENU = 2'd0,
        MODE_CHASE = 2'd1,
        MODE_BREATH = 2'd2,
        MODE_DONE = 2'd3
    } t_mode;

    typedef struct packed {
        logic [FIELD_CHANNELS-1:0][DUTY_W-1:0] duty;
        logic [MENU_W-1:0] menu;
        t_mode mode;
    } t_result;

    // menu steps 0, 1, 2 and wraps
    function automatic logic [MENU_W-1:0] menu_next(input logic [MENU_W-1:0] m);
        menu_next = (m == MENU_EXIT) ? MENU_CHASE : m + MENU_W'(1);
    endfunction

endpackage

### rtl/core/lcbs_if.sv
`timescale 1ns / 1ps

// input channel: one key word per tick
interface lcbs_in_if;
    logic valid;
    logic ready;
    logic [lcbs_pkg::KEY_W-1:0] key_code;

    modport source (output valid, output key_code, input ready);
    modport sink (input valid, input key_code, output ready);
endinterface

// output channel: duties and status per tick
interface lcbs_out_if;
    logic valid;
    logic ready;
    logic [lcbs_pkg::DUTY_W-1:0] duty_first;
    logic [lcbs_pkg::DUTY_W-1:0] duty_second;
    logic [lcbs_pkg::DUTY_W-1:0] duty_third;
    logic [lcbs_pkg::DUTY_W-1:0] duty_fourth;
    logic [lcbs_pkg::MENU_W-1:0] menu_shown;
    logic [lcbs_pkg::MODE_W-1:0] mode_now;

    modport source (output valid, output duty_first, output duty_second,
                    output duty_third, output duty_fourth, output menu_shown,
                    output mode_now, input ready);
    modport sink (input valid, input duty_first, input duty_second,
                  input duty_third, input duty_fourth, input menu_shown,
                  input mode_now, output ready);
endinterface

### rtl/core/lcbs_step.sv
`timescale 1ns / 1ps

module lcbs_step #(
    parameter int CHANNELS = lcbs_pkg::CHANNELS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,
    input  logic [lcbs_pkg::KEY_W-1:0]    i_key,
    input  logic [lcbs_pkg::DUTY_W-1:0]   i_half,
    input  logic [lcbs_pkg::DUTY_W-1:0]   i_full,
    output lcbs_pkg::t_result             o_res
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

    logic [lcbs_pkg::MENU_W-1:0] r_menu, n_menu;
    lcbs_pkg::t_mode             r_mode, n_mode;
    logic [CH_W-1:0]             r_chan, n_chan;
    logic                        r_fall, n_fall;
    logic [lcbs_pkg::TICK_W-1:0] r_tick, n_tick;
    logic [lcbs_pkg::DUTY_W-1:0] r_ramp, n_ramp;

    logic                        lit;
    logic [lcbs_pkg::DUTY_W-1:0] level;
    logic [lcbs_pkg::DUTY_W-1:0] ramp_p;
    logic [lcbs_pkg::TICK_W-1:0] last_tick;
    logic [CH_W-1:0]             chan_next;

    assign last_tick = {i_half, 1'b0} - lcbs_pkg::TICK_W'(1);
    assign ramp_p = (r_ramp > i_full) ? i_full : r_ramp;
    assign chan_next = (r_chan == CH_LAST) ? '0 : r_chan + CH_W'(1);

    // next state and level for this tick
    always_comb begin
        n_menu = r_menu;
        n_mode = r_mode;
        n_chan = r_chan;
        n_fall = r_fall;
        n_tick = r_tick;
        n_ramp = r_ramp;
        lit = 1'b0;
        level = '0;
        case (r_mode)
            lcbs_pkg::MODE_MENU: begin
                if (i_key == lcbs_pkg::KEY_NEXT) begin
                    n_menu = lcbs_pkg::menu_next(r_menu);
                end else if (i_key == lcbs_pkg::KEY_SELECT) begin
                    n_chan = '0;
                    n_fall = 1'b0;
                    n_tick = '0;
                    n_ramp = '0;
                    case (r_menu)
                        lcbs_pkg::MENU_CHASE:  n_mode = lcbs_pkg::MODE_CHASE;
                        lcbs_pkg::MENU_BREATH: n_mode = lcbs_pkg::MODE_BREATH;
                        default:               n_mode = lcbs_pkg::MODE_DONE;
                    endcase
                end
            end
            lcbs_pkg::MODE_CHASE: begin
                if (r_tick < {1'b0, i_half}) begin
                    lit = 1'b1;
                    level = i_full;
                end
                if (r_tick >= last_tick) begin
                    if (i_key == lcbs_pkg::KEY_NEXT) begin
                        n_mode = lcbs_pkg::MODE_MENU;
                        n_menu = lcbs_pkg::menu_next(r_menu);
                        lit = 1'b0;
                    end else begin
                        n_tick = '0;
                        n_chan = chan_next;
                    end
                end else begin
                    n_tick = r_tick + lcbs_pkg::TICK_W'(1);
                end
            end
            lcbs_pkg::MODE_BREATH: begin
                lit = 1'b1;
                level = r_fall ? i_full - ramp_p : ramp_p;
                if (i_key == lcbs_pkg::KEY_NEXT) begin
                    n_mode = lcbs_pkg::MODE_MENU;
                    n_menu = lcbs_pkg::menu_next(r_menu);
                    lit = 1'b0;
                end else if (ramp_p >= i_full) begin
                    n_ramp = '0;
                    n_fall = ~r_fall;
                    if (r_fall) begin
                        n_chan = chan_next;
                    end
                end else begin
                    n_ramp = ramp_p + lcbs_pkg::DUTY_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // result word: duties for this tick, menu and mode after it
    always_comb begin
        for (int k = 0; k < lcbs_pkg::FIELD_CHANNELS; k++) begin
            o_res.duty[k] = (lit && (int'(r_chan) == k)) ? level : '0;
        end
        o_res.menu = n_menu;
        o_res.mode = n_mode;
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_menu <= lcbs_pkg::MENU_CHASE;
            r_mode <= lcbs_pkg::MODE_MENU;
            r_chan <= '0;
            r_fall <= 1'b0;
            r_tick <= '0;
            r_ramp <= '0;
        end else if (i_take) begin
            r_menu <= n_menu;
            r_mode <= n_mode;
            r_chan <= n_chan;
            r_fall <= n_fall;
            r_tick <= n_tick;
            r_ramp <= n_ramp;
        end
    end

endmodule

### rtl/core/lcbs_out_buf.sv
`timescale 1ns / 1ps

module lcbs_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lcbs_pkg::t_result i_data,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output lcbs_pkg::t_result o_data
);

    logic              r_main_valid;
    logic              r_skid_valid;
    lcbs_pkg::t_result r_main;
    lcbs_pkg::t_result r_skid;
    logic              pop;

    assign pop = r_main_valid & i_ready;
    assign o_room = ~r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data = r_main;

    // valid flags of the output register and skid slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            if (r_main_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
            end else if (i_push) begin
                r_main <= i_data;
            end
        end else if (i_push) begin
            if (r_main_valid) begin
                r_skid <= i_data;
            end else begin
                r_main <= i_data;
            end
        end
    end

endmodule

### rtl/core/led_chase_and_breathing_sequencer_core.sv
`timescale 1ns / 1ps

// channel   dir  handshake      payload
// i_in      in   valid/ready    key_code
// o_out     out  valid/ready    duty_first..duty_fourth, menu_shown, mode_now
// i_cfg_*   in   write enable   idx 0 blink_half_ticks, idx 1 duty_full
//
// one tick word per clock while i_in.ready is high; its result is registered
// in the output register, or in the skid slot while the sink stalls.
// i_rst_n is synchronous: menu mode, menu entry 0, registers 10 and 100.
// a two-entry output stage (register plus skid) lets one more word in while
// the sink stalls; i_in.ready drops only when both entries are full.

module led_chase_and_breathing_sequencer_core #(
    parameter int CHANNELS = lcbs_pkg::CHANNELS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    lcbs_in_if.sink                         i_in,
    lcbs_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [lcbs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lcbs_pkg::DUTY_W-1:0]     i_cfg_data
);

    logic [lcbs_pkg::DUTY_W-1:0] r_half;
    logic [lcbs_pkg::DUTY_W-1:0] r_full;
    logic [lcbs_pkg::DUTY_W-1:0] cfg_val;
    logic                        take;
    logic                        room;
    lcbs_pkg::t_result           step_res;
    lcbs_pkg::t_result           out_res;

    // a zero register behaves as one, so store it that way
    assign cfg_val = (i_cfg_data == '0) ? lcbs_pkg::DUTY_W'(1) : i_cfg_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= lcbs_pkg::HALF_RESET;
            r_full <= lcbs_pkg::FULL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lcbs_pkg::CFG_BLINK_HALF: r_half <= cfg_val;
                lcbs_pkg::CFG_DUTY_FULL:  r_full <= cfg_val;
                default: begin
                end
            endcase
        end
    end

    assign i_in.ready = room;
    assign take = i_in.valid & room;

    lcbs_step #(
        .CHANNELS(CHANNELS)
    ) u_step (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_take (take),
        .i_key  (i_in.key_code),
        .i_half (r_half),
        .i_full (r_full),
        .o_res  (step_res)
    );

    lcbs_out_buf u_out_buf (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (take),
        .i_data (step_res),
        .o_room (room),
        .o_valid(o_out.valid),
        .i_ready(o_out.ready),
        .o_data (out_res)
    );

    // result word onto the output channel
    assign o_out.duty_first = out_res.duty[0];
    assign o_out.duty_second = out_res.duty[1];
    assign o_out.duty_third = out_res.duty[2];
    assign o_out.duty_fourth = out_res.duty[3];
    assign o_out.menu_shown = out_res.menu;
    assign o_out.mode_now = out_res.mode;

endmodule
